// ===== rtl/core/lrsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lrsf_pkg
// Shared types and constants of the three-wire LCD serial frame generator.
// ----------------------------------------------------------------------------
package lrsf_pkg;

  // request modes
  localparam logic [1:0] MODE_CMD        = 2'd0;
  localparam logic [1:0] MODE_WRITE      = 2'd1;
  localparam logic [1:0] MODE_BURST_OPEN = 2'd2;
  localparam logic [1:0] MODE_BURST_BYTE = 2'd3;

  // frame prefixes, sent msb first
  localparam logic [2:0] CMD_PREFIX   = 3'b100;
  localparam logic [2:0] WRITE_PREFIX = 3'b101;

  // longest frame and bit counter width
  localparam int unsigned MAX_BITS = 13;
  localparam int unsigned CNT_W    = 4;

  // frame lengths in bits
  localparam logic [CNT_W-1:0] LEN_CMD   = 4'd12;
  localparam logic [CNT_W-1:0] LEN_WRITE = 4'd13;
  localparam logic [CNT_W-1:0] LEN_OPEN  = 4'd9;
  localparam logic [CNT_W-1:0] LEN_BYTE  = 4'd8;
  localparam logic [CNT_W-1:0] LEN_ERR   = 4'd1;

  // decoded frame passed from front to back, bits[0] goes out first
  typedef struct packed {
    logic [MAX_BITS-1:0] bits;
    logic [CNT_W-1:0]    count;
    logic                rel_en;
    logic                err;
  } frame_t;

endpackage

// ===== rtl/core/lrsf_in_if.sv =====
// ----------------------------------------------------------------------------
// lrsf_in_if
// Request channel: valid/ready handshake with the controller request fields.
// ----------------------------------------------------------------------------
interface lrsf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [5:0] ram_address;
  logic [7:0] payload;
  logic       end_of_frame;

  modport source (output valid, output mode, output ram_address, output payload,
                  output end_of_frame, input ready);
  modport sink (input valid, input mode, input ram_address, input payload,
                input end_of_frame, output ready);
endinterface

// ===== rtl/core/lrsf_out_if.sv =====
// ----------------------------------------------------------------------------
// lrsf_out_if
// Result channel: one transaction per serial bit with its frame flags.
// ----------------------------------------------------------------------------
interface lrsf_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic select_release;
  logic last_of_item;
  logic sequence_error;

  modport source (output valid, output serial_bit, output select_release,
                  output last_of_item, output sequence_error, input ready);
  modport sink (input valid, input serial_bit, input select_release,
                input last_of_item, input sequence_error, output ready);
endinterface

// ===== rtl/core/lcd_ram_serial_frame_generator_core.sv =====
// ----------------------------------------------------------------------------
// lcd_ram_serial_frame_generator_core
// Three-wire LCD serial frame generator: requests in, one bit per transaction out.
// ----------------------------------------------------------------------------
// a request passes through the frame queue, the shift register and the output register
// the serializer sends one bit per cycle while the result side is ready; a request
//   gives as many bits as its frame holds: 1 (ordering error), 8, 9, 12 or 13
// a two-entry frame queue lets requests be accepted while bits are still out
// reset: synchronous active-low rst_n closes any burst and empties the pipe
module lcd_ram_serial_frame_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  lrsf_in_if.sink     in_ch,
  lrsf_out_if.source  out_ch
);

  logic             push_valid;
  logic             push_ready;
  lrsf_pkg::frame_t push_data;
  logic             pop_valid;
  logic             pop_ready;
  lrsf_pkg::frame_t pop_data;

  // request decode
  lrsf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // frame queue
  lrsf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // bit serializer
  lrsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .res       (out_ch)
  );

endmodule

// ===== rtl/core/lrsf_front.sv =====
// ----------------------------------------------------------------------------
// lrsf_front
// Accepts requests, checks burst ordering and builds the bit frame.
// ----------------------------------------------------------------------------
module lrsf_front (
  input  logic              clk,
  input  logic              rst_n,
  lrsf_in_if.sink           req,
  output logic              push_valid,
  input  logic              push_ready,
  output lrsf_pkg::frame_t  push_data
);

  logic burst_open_r;
  logic burst_open_nxt;
  logic accept;
  logic bad;

  assign req.ready  = push_ready;
  assign push_valid = req.valid;
  assign accept     = req.valid && push_ready;

  // out-of-order check against the open burst
  assign bad = (req.mode == lrsf_pkg::MODE_BURST_BYTE) ? !burst_open_r : burst_open_r;

  // frame build
  always_comb begin
    push_data = '0;
    if (bad) begin
      push_data.count = lrsf_pkg::LEN_ERR;
      push_data.err   = 1'b1;
    end else begin
      case (req.mode)
        lrsf_pkg::MODE_CMD: begin
          for (int i = 0; i < 3; i++) push_data.bits[i] = lrsf_pkg::CMD_PREFIX[2-i];
          for (int i = 0; i < 8; i++) push_data.bits[3+i] = req.payload[7-i];
          push_data.count  = lrsf_pkg::LEN_CMD;
          push_data.rel_en = 1'b1;
        end
        lrsf_pkg::MODE_WRITE: begin
          for (int i = 0; i < 3; i++) push_data.bits[i] = lrsf_pkg::WRITE_PREFIX[2-i];
          for (int i = 0; i < 6; i++) push_data.bits[3+i] = req.ram_address[5-i];
          for (int i = 0; i < 4; i++) push_data.bits[9+i] = req.payload[i];
          push_data.count  = lrsf_pkg::LEN_WRITE;
          push_data.rel_en = 1'b1;
        end
        lrsf_pkg::MODE_BURST_OPEN: begin
          for (int i = 0; i < 3; i++) push_data.bits[i] = lrsf_pkg::WRITE_PREFIX[2-i];
          for (int i = 0; i < 6; i++) push_data.bits[3+i] = req.ram_address[5-i];
          push_data.count  = lrsf_pkg::LEN_OPEN;
          push_data.rel_en = req.end_of_frame;
        end
        default: begin
          for (int i = 0; i < 8; i++) push_data.bits[i] = req.payload[i];
          push_data.count  = lrsf_pkg::LEN_BYTE;
          push_data.rel_en = req.end_of_frame;
        end
      endcase
    end
  end

  // burst state follows accepted transactions
  always_comb begin
    burst_open_nxt = burst_open_r;
    if (accept && !bad) begin
      if (req.mode == lrsf_pkg::MODE_BURST_OPEN) begin
        burst_open_nxt = !req.end_of_frame;
      end else if (req.mode == lrsf_pkg::MODE_BURST_BYTE && req.end_of_frame) begin
        burst_open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_open_r <= 1'b0;
    end else begin
      burst_open_r <= burst_open_nxt;
    end
  end

endmodule

// ===== rtl/core/lrsf_queue.sv =====
// ----------------------------------------------------------------------------
// lrsf_queue
// Two-entry frame queue decoupling the request side from the serializer.
// ----------------------------------------------------------------------------
module lrsf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  lrsf_pkg::frame_t  push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output lrsf_pkg::frame_t  pop_data
);

  lrsf_pkg::frame_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  logic       pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/lrsf_back.sv =====
// ----------------------------------------------------------------------------
// lrsf_back
// Serializer: shifts one frame bit per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
module lrsf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  lrsf_pkg::frame_t  pop_data,
  lrsf_out_if.source        res
);

  logic                                active_r, active_nxt;
  logic [lrsf_pkg::MAX_BITS-1:0]       sh_r, sh_nxt;
  logic [lrsf_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                                rel_r, rel_nxt;
  logic                                err_r, err_nxt;
  logic                                ov_r, ov_nxt;
  logic                                obit_r, obit_nxt;
  logic                                orel_r, orel_nxt;
  logic                                olast_r, olast_nxt;
  logic                                oerr_r, oerr_nxt;
  logic                                out_free;
  logic                                advance;
  logic                                last_bit;

  assign out_free  = !ov_r || res.ready;
  assign advance   = active_r && out_free;
  assign last_bit  = (cnt_r == lrsf_pkg::CNT_W'(1));
  assign pop_ready = !active_r || (advance && last_bit);

  // shift and output stage
  always_comb begin
    active_nxt = active_r;
    sh_nxt     = sh_r;
    cnt_nxt    = cnt_r;
    rel_nxt    = rel_r;
    err_nxt    = err_r;
    ov_nxt     = ov_r && !res.ready;
    obit_nxt   = obit_r;
    orel_nxt   = orel_r;
    olast_nxt  = olast_r;
    oerr_nxt   = oerr_r;
    if (advance) begin
      ov_nxt     = 1'b1;
      obit_nxt   = sh_r[0];
      orel_nxt   = last_bit && rel_r;
      olast_nxt  = last_bit;
      oerr_nxt   = err_r;
      sh_nxt     = sh_r >> 1;
      cnt_nxt    = cnt_r - lrsf_pkg::CNT_W'(1);
      active_nxt = !last_bit;
    end
    // load next frame from the queue
    if (pop_valid && pop_ready) begin
      active_nxt = 1'b1;
      sh_nxt     = pop_data.bits;
      cnt_nxt    = pop_data.count;
      rel_nxt    = pop_data.rel_en;
      err_nxt    = pop_data.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r    <= sh_nxt;
    cnt_r   <= cnt_nxt;
    rel_r   <= rel_nxt;
    err_r   <= err_nxt;
    obit_r  <= obit_nxt;
    orel_r  <= orel_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
  end

  assign res.valid          = ov_r;
  assign res.serial_bit     = obit_r;
  assign res.select_release = orel_r;
  assign res.last_of_item   = olast_r;
  assign res.sequence_error = oerr_r;

endmodule

// ===== dv/tb_lcd_ram_serial_frame_generator_core.sv =====
// ----------------------------------------------------------------------------
// tb_lcd_ram_serial_frame_generator_core
// Self-checking bench for the three-wire LCD serial frame generator. A table
// of directed requests covers field extremes, every mode and the ordering
// errors, followed by random command, write and burst sequences mixed with
// broken ones. Every serial bit is checked against a typed or predicted frame
// while both sides idle at random and the result side stalls once for long.
// ----------------------------------------------------------------------------
module tb_lcd_ram_serial_frame_generator_core;

  localparam int TOTAL_ITEMS     = 210;
  localparam int QUIET_ITEMS     = 30;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int PRINT_LIMIT     = 50;

  // one request as driven on the input channel
  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] ram_address;
    logic [7:0] payload;
    logic       end_of_frame;
  } request_t;

  // expected frame: bits right aligned, first bit out at [len-1]
  typedef struct {
    logic [12:0] bits;
    int          len;
    logic        rel;
    logic        err;
  } frame_exp_t;

  // one stimulus row, with a typed-in frame where it is obvious
  typedef struct {
    request_t   req;
    bit         typed;
    frame_exp_t want;
  } stim_row_t;

  // one serial bit transaction
  typedef struct packed {
    logic serial_bit;
    logic select_release;
    logic last_of_item;
    logic sequence_error;
  } bit_result_t;

  logic clk;
  logic rst_n;

  lrsf_in_if  in_ch ();
  lrsf_out_if out_ch ();

  lcd_ram_serial_frame_generator_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stim_row_t   stim_rows[$];
  stim_row_t   cur_row;
  bit_result_t expected_bits[$];
  logic        burst_active;

  int  fail_count     = 0;
  int  items_sent     = 0;
  int  items_accepted = 0;
  int  bits_checked   = 0;
  int  order_errors   = 0;
  int  bursts_closed  = 0;
  bit  quiet          = 1'b0;
  bit  hold_off_req   = 1'b0;
  bit  hold_off_done  = 1'b0;

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one line per mismatch, counted
  task automatic report_mismatch(input string what, input logic got, input logic want);
    if (fail_count < PRINT_LIMIT) begin
      $display("mismatch on %s at bit %0d: got %b expected %b", what, bits_checked, got, want);
    end
    fail_count++;
  endtask

  // frame predictor, keeps its own burst state
  task automatic serialize_request(input request_t r, output frame_exp_t f);
    logic bad;
    bad = (r.mode == lrsf_pkg::MODE_BURST_BYTE) ? !burst_active : burst_active;
    f.bits = '0;
    f.len  = 1;
    f.rel  = 1'b0;
    f.err  = 1'b0;
    if (bad) begin
      f.err = 1'b1;
    end else begin
      case (r.mode)
        lrsf_pkg::MODE_CMD: begin
          f.bits = {1'b0, lrsf_pkg::CMD_PREFIX, r.payload, 1'b0};
          f.len  = 12;
          f.rel  = 1'b1;
        end
        lrsf_pkg::MODE_WRITE: begin
          f.bits = {lrsf_pkg::WRITE_PREFIX, r.ram_address,
                    r.payload[0], r.payload[1], r.payload[2], r.payload[3]};
          f.len  = 13;
          f.rel  = 1'b1;
        end
        lrsf_pkg::MODE_BURST_OPEN: begin
          f.bits = {4'b0, lrsf_pkg::WRITE_PREFIX, r.ram_address};
          f.len  = 9;
          f.rel  = r.end_of_frame;
          burst_active = !r.end_of_frame;
        end
        default: begin
          for (int i = 0; i < 8; i++) f.bits[7-i] = r.payload[i];
          f.len = 8;
          f.rel = r.end_of_frame;
          if (r.end_of_frame) burst_active = 1'b0;
        end
      endcase
    end
  endtask

  // expand a frame into per-bit expectations
  task automatic push_frame(input frame_exp_t f);
    bit_result_t b;
    for (int i = f.len - 1; i >= 0; i--) begin
      b.serial_bit     = f.err ? 1'b0 : f.bits[i];
      b.select_release = (i == 0) ? f.rel : 1'b0;
      b.last_of_item   = (i == 0);
      b.sequence_error = f.err;
      expected_bits.push_back(b);
    end
  endtask

  task automatic add_row(input logic [1:0] mode, input logic [5:0] addr,
                         input logic [7:0] payload, input logic eof, input bit typed,
                         input logic [12:0] bits, input int len, input logic rel,
                         input logic err);
    stim_row_t row;
    row.req.mode         = mode;
    row.req.ram_address  = addr;
    row.req.payload      = payload;
    row.req.end_of_frame = eof;
    row.typed     = typed;
    row.want.bits = bits;
    row.want.len  = len;
    row.want.rel  = rel;
    row.want.err  = err;
    stim_rows.push_back(row);
  endtask

  // offer one request and wait for its handshake
  task automatic send_request(input stim_row_t row);
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= row.req.mode;
    in_ch.ram_address  <= row.req.ram_address;
    in_ch.payload      <= row.req.payload;
    in_ch.end_of_frame <= row.req.end_of_frame;
    cur_row            <= row;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    // random sender gap
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // request with random content in every field but mode and end flag
  task automatic send_random(input logic [1:0] mode, input logic eof);
    stim_row_t   row;
    logic [31:0] r;
    r = $urandom;
    row.req.mode         = mode;
    row.req.ram_address  = r[5:0];
    row.req.payload      = r[13:6];
    row.req.end_of_frame = eof;
    row.typed = 1'b0;
    row.want  = '{bits: '0, len: 1, rel: 1'b0, err: 1'b0};
    send_request(row);
  endtask

  // scoreboard: predict on input transactions, check output transactions
  always @(posedge clk) begin : scoreboard
    frame_exp_t  predicted;
    request_t    req;
    bit_result_t got;
    bit_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        req = {in_ch.mode, in_ch.ram_address, in_ch.payload, in_ch.end_of_frame};
        serialize_request(req, predicted);
        push_frame(cur_row.typed ? cur_row.want : predicted);
        items_accepted++;
        if (predicted.err) order_errors++;
        if (!predicted.err && predicted.rel && req.mode != lrsf_pkg::MODE_CMD &&
            req.mode != lrsf_pkg::MODE_WRITE)
          bursts_closed++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.serial_bit, out_ch.select_release,
               out_ch.last_of_item, out_ch.sequence_error};
        if (expected_bits.size() == 0) begin
          if (fail_count < PRINT_LIMIT)
            $display("unexpected bit transaction %b after bit %0d", got, bits_checked);
          fail_count++;
        end else begin
          want = expected_bits.pop_front();
          if (got.serial_bit !== want.serial_bit)
            report_mismatch("serial_bit", got.serial_bit, want.serial_bit);
          if (got.select_release !== want.select_release)
            report_mismatch("select_release", got.select_release, want.select_release);
          if (got.last_of_item !== want.last_of_item)
            report_mismatch("last_of_item", got.last_of_item, want.last_of_item);
          if (got.sequence_error !== want.sequence_error)
            report_mismatch("sequence_error", got.sequence_error, want.sequence_error);
          bits_checked++;
        end
      end
    end
  end

  // result side: random stalls, one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // watchdog
  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

  // main sequence
  initial begin
    int pick;
    int nbytes;
    int waited;
    rst_n              = 1'b0;
    burst_active       = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = lrsf_pkg::MODE_CMD;
    in_ch.ram_address  = '0;
    in_ch.payload      = '0;
    in_ch.end_of_frame = 1'b0;

    // directed table: mode, address, payload, end, typed, bits, length, release, error
    add_row(lrsf_pkg::MODE_BURST_BYTE, 6'h3F, 8'hFF, 1'b1, 1'b1, 13'b0, 1, 1'b0, 1'b1);
    add_row(lrsf_pkg::MODE_CMD, 6'h00, 8'hFF, 1'b0, 1'b1, 13'b0_1001_1111_1110, 12, 1'b1, 1'b0);
    add_row(lrsf_pkg::MODE_CMD, 6'h3F, 8'h00, 1'b1, 1'b1, 13'b0_1000_0000_0000, 12, 1'b1, 1'b0);
    add_row(lrsf_pkg::MODE_WRITE, 6'h3F, 8'hF5, 1'b0, 1'b1, 13'b1_0111_1111_1010, 13, 1'b1,
            1'b0);
    add_row(lrsf_pkg::MODE_WRITE, 6'h00, 8'h0F, 1'b1, 1'b1, 13'b1_0100_0000_1111, 13, 1'b1,
            1'b0);
    add_row(lrsf_pkg::MODE_BURST_OPEN, 6'h2A, 8'hFF, 1'b0, 1'b1, 13'b0_0001_0110_1010, 9,
            1'b0, 1'b0);
    // anything but a burst byte inside an open burst is out of order
    add_row(lrsf_pkg::MODE_CMD, 6'h15, 8'h55, 1'b0, 1'b1, 13'b0, 1, 1'b0, 1'b1);
    add_row(lrsf_pkg::MODE_WRITE, 6'h2A, 8'hAA, 1'b1, 1'b1, 13'b0, 1, 1'b0, 1'b1);
    add_row(lrsf_pkg::MODE_BURST_OPEN, 6'h3F, 8'hFF, 1'b1, 1'b1, 13'b0, 1, 1'b0, 1'b1);
    add_row(lrsf_pkg::MODE_BURST_BYTE, 6'h00, 8'h80, 1'b0, 1'b0, 13'b0, 1, 1'b0, 1'b0);
    add_row(lrsf_pkg::MODE_BURST_BYTE, 6'h3F, 8'h01, 1'b0, 1'b0, 13'b0, 1, 1'b0, 1'b0);
    add_row(lrsf_pkg::MODE_BURST_BYTE, 6'h15, 8'hA5, 1'b1, 1'b0, 13'b0, 1, 1'b0, 1'b0);
    add_row(lrsf_pkg::MODE_BURST_BYTE, 6'h2A, 8'h00, 1'b0, 1'b1, 13'b0, 1, 1'b0, 1'b1);
    // burst opened and closed at once: header only
    add_row(lrsf_pkg::MODE_BURST_OPEN, 6'h3F, 8'h00, 1'b1, 1'b1, 13'b0_0001_0111_1111, 9,
            1'b1, 1'b0);
    add_row(lrsf_pkg::MODE_BURST_BYTE, 6'h3F, 8'hFF, 1'b1, 1'b1, 13'b0, 1, 1'b0, 1'b1);
    add_row(lrsf_pkg::MODE_CMD, 6'h15, 8'hA5, 1'b1, 1'b0, 13'b0, 1, 1'b0, 1'b0);
    add_row(lrsf_pkg::MODE_WRITE, 6'h2A, 8'h5A, 1'b1, 1'b0, 13'b0, 1, 1'b0, 1'b0);
    add_row(lrsf_pkg::MODE_BURST_OPEN, 6'h15, 8'h3C, 1'b0, 1'b0, 13'b0, 1, 1'b0, 1'b0);
    add_row(lrsf_pkg::MODE_BURST_BYTE, 6'h2A, 8'hFF, 1'b0, 1'b0, 13'b0, 1, 1'b0, 1'b0);
    add_row(lrsf_pkg::MODE_BURST_BYTE, 6'h00, 8'h00, 1'b0, 1'b0, 13'b0, 1, 1'b0, 1'b0);
    add_row(lrsf_pkg::MODE_BURST_BYTE, 6'h3F, 8'h5A, 1'b1, 1'b0, 13'b0, 1, 1'b0, 1'b0);
    add_row(lrsf_pkg::MODE_BURST_OPEN, 6'h00, 8'hC3, 1'b1, 1'b0, 13'b0, 1, 1'b0, 1'b0);
    add_row(lrsf_pkg::MODE_CMD, 6'h2A, 8'h01, 1'b0, 1'b0, 13'b0, 1, 1'b0, 1'b0);

    // reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) send_request(stim_rows[i]);

    // random part: long result stall first, then well-formed frames with some noise
    hold_off_req = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      quiet = (items_sent >= TOTAL_ITEMS - QUIET_ITEMS);
      pick  = $urandom_range(0, 9);
      if (pick <= 2) begin
        send_random(lrsf_pkg::MODE_CMD, 1'($urandom_range(0, 1)));
      end else if (pick <= 4) begin
        send_random(lrsf_pkg::MODE_WRITE, 1'($urandom_range(0, 1)));
      end else if (pick <= 8) begin
        if ($urandom_range(0, 7) == 0) begin
          send_random(lrsf_pkg::MODE_BURST_OPEN, 1'b1);
        end else begin
          send_random(lrsf_pkg::MODE_BURST_OPEN, 1'b0);
          nbytes = $urandom_range(1, 4);
          for (int k = 0; k < nbytes; k++) begin
            if ($urandom_range(0, 5) == 0)
              send_random(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
            send_random(lrsf_pkg::MODE_BURST_BYTE, k == nbytes - 1);
          end
        end
      end else begin
        send_random(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    end
    in_ch.valid <= 1'b0;

    // drain
    waited = 0;
    @(posedge clk);
    while (expected_bits.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_bits.size() != 0) begin
      $display("%0d expected bits never arrived", expected_bits.size());
      fail_count += expected_bits.size();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests (%0d out of order, %0d bursts closed) gave %0d checked bits",
             items_accepted, order_errors, bursts_closed, bits_checked);
    $display("covered commands, nibble writes, open bursts, long result stall, random idling");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
